@@ rtl/core/sts_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg: shared types and codes for the script token scanner
// Result record layout, result kind codes and scanner mode codes.
// ----------------------------------------------------------------------------
package sts_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_EOD  = 2'd2;

  // scanner modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_SLASH   = 3'd1;
  localparam logic [2:0] MODE_COMMENT = 3'd2;
  localparam logic [2:0] MODE_QUOTE   = 3'd3;
  localparam logic [2:0] MODE_WORD    = 3'd4;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // one result record
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] token_char;
    logic [7:0] token_length;
    logic       was_quoted;
    logic       discarded;
    logic       last_of_run;
  } result_t;

endpackage
`default_nettype wire

@@ rtl/core/script_token_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// script_token_scanner: byte-serial tokeniser for script text
// Skips whitespace and line comments, emits token bytes and token-end records.
// ----------------------------------------------------------------------------
// One text byte is taken per transfer. Each byte is decoded in the cycle it is
// taken and its results (zero to three records) are loaded into a three-entry
// result register, which drains one record per cycle to the output while
// out_stall is low. Bytes causing at most one record each stream at one per
// cycle while the output does not stall; a byte causing more records holds
// back later bytes until the single output port has taken them. A new byte is
// taken when the register holds only the record leaving in the same cycle.
// A zero byte ends the string: open tokens are closed, an end-of-data record
// follows and the scanner is ready for the next string.
module script_token_scanner #(
  parameter int TOKEN_MAX = 128
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_char_code,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_token_char,
  output logic [7:0] out_token_length,
  output logic       out_was_quoted,
  output logic       out_discarded,
  output logic       out_last_of_run
);

  localparam int CW = $clog2(TOKEN_MAX + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(TOKEN_MAX);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);

  logic [2:0]      mode_r, mode_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      fill_r, fill_nxt;
  sts_pkg::result_t res_r   [3];
  sts_pkg::result_t res_nxt [3];
  sts_pkg::result_t dec     [3];
  logic [1:0]      dec_n;
  logic            in_xfer, out_xfer;

  assign out_valid = (fill_r != 2'd0);
  assign out_xfer  = out_valid && !out_stall;
  assign in_stall  = !((fill_r == 2'd0) || ((fill_r == 2'd1) && !out_stall));
  assign in_xfer   = in_valid && !in_stall;

  assign out_kind         = res_r[0].kind;
  assign out_token_char   = res_r[0].token_char;
  assign out_token_length = res_r[0].token_length;
  assign out_was_quoted   = res_r[0].was_quoted;
  assign out_discarded    = res_r[0].discarded;
  assign out_last_of_run  = res_r[0].last_of_run;

  // decode one byte into records and the next scanner state
  always_comb begin
    logic [7:0]      c;
    logic [CW+7:0]   len_ext;
    logic            full;
    c         = in_char_code;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    dec_n     = 2'd0;
    len_ext   = '0;
    full      = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dec[i] = '0;
    end

    case (mode_r)
      sts_pkg::MODE_SLASH: begin
        if (c == sts_pkg::CH_SLASH) begin
          mode_nxt = sts_pkg::MODE_COMMENT;
        end else begin
          // emit the held slash as the first word byte
          mode_nxt  = sts_pkg::MODE_WORD;
          count_nxt = CNT_ONE;
          dec[0].kind       = sts_pkg::KIND_BYTE;
          dec[0].token_char = sts_pkg::CH_SLASH;
          dec_n = 2'd1;
          if (c > sts_pkg::CH_SPACE) begin
            if (CNT_ONE < CNT_MAX) begin
              count_nxt = CW'(2);
              dec[1].kind       = sts_pkg::KIND_BYTE;
              dec[1].token_char = c;
              dec_n = 2'd2;
            end
          end else begin
            full    = (CNT_ONE == CNT_MAX);
            len_ext = {8'd0, CNT_ONE};
            dec[1].kind         = sts_pkg::KIND_END;
            dec[1].token_length = full ? 8'd0 : len_ext[7:0];
            dec[1].discarded    = full;
            dec_n     = 2'd2;
            count_nxt = '0;
            mode_nxt  = sts_pkg::MODE_IDLE;
            if (c == sts_pkg::CH_NUL) begin
              dec[2].kind = sts_pkg::KIND_EOD;
              dec_n = 2'd3;
            end
          end
        end
      end
      sts_pkg::MODE_COMMENT: begin
        if (c == sts_pkg::CH_NUL) begin
          dec[0].kind = sts_pkg::KIND_EOD;
          dec_n    = 2'd1;
          mode_nxt = sts_pkg::MODE_IDLE;
        end else if (c == sts_pkg::CH_NL) begin
          mode_nxt = sts_pkg::MODE_IDLE;
        end
      end
      sts_pkg::MODE_QUOTE: begin
        if (c == sts_pkg::CH_QUOTE || c == sts_pkg::CH_NUL) begin
          len_ext = {8'd0, count_r};
          dec[0].kind         = sts_pkg::KIND_END;
          dec[0].token_length = len_ext[7:0];
          dec[0].was_quoted   = 1'b1;
          dec_n = 2'd1;
          if (c == sts_pkg::CH_NUL) begin
            dec[1].kind = sts_pkg::KIND_EOD;
            dec_n = 2'd2;
          end
          count_nxt = '0;
          mode_nxt  = sts_pkg::MODE_IDLE;
        end else if (count_r < CNT_MAX) begin
          count_nxt = count_r + CNT_ONE;
          dec[0].kind       = sts_pkg::KIND_BYTE;
          dec[0].token_char = c;
          dec_n = 2'd1;
        end
      end
      sts_pkg::MODE_WORD: begin
        if (c > sts_pkg::CH_SPACE) begin
          // drop bytes past the limit
          if (count_r < CNT_MAX) begin
            count_nxt = count_r + CNT_ONE;
            dec[0].kind       = sts_pkg::KIND_BYTE;
            dec[0].token_char = c;
            dec_n = 2'd1;
          end
        end else begin
          full    = (count_r == CNT_MAX);
          len_ext = {8'd0, count_r};
          dec[0].kind         = sts_pkg::KIND_END;
          dec[0].token_length = full ? 8'd0 : len_ext[7:0];
          dec[0].discarded    = full;
          dec_n     = 2'd1;
          count_nxt = '0;
          mode_nxt  = sts_pkg::MODE_IDLE;
          if (c == sts_pkg::CH_NUL) begin
            dec[1].kind = sts_pkg::KIND_EOD;
            dec_n = 2'd2;
          end
        end
      end
      default: begin
        // between tokens, and unused mode codes
        mode_nxt  = sts_pkg::MODE_IDLE;
        count_nxt = '0;
        if (c == sts_pkg::CH_NUL) begin
          dec[0].kind = sts_pkg::KIND_EOD;
          dec_n = 2'd1;
        end else if (c <= sts_pkg::CH_SPACE) begin
          mode_nxt = sts_pkg::MODE_IDLE;
        end else if (c == sts_pkg::CH_SLASH) begin
          mode_nxt = sts_pkg::MODE_SLASH;
        end else if (c == sts_pkg::CH_QUOTE) begin
          mode_nxt = sts_pkg::MODE_QUOTE;
        end else begin
          mode_nxt  = sts_pkg::MODE_WORD;
          count_nxt = CNT_ONE;
          dec[0].kind       = sts_pkg::KIND_BYTE;
          dec[0].token_char = c;
          dec_n = 2'd1;
        end
      end
    endcase

    // mark the final record of this byte
    case (dec_n)
      2'd1:    dec[0].last_of_run = 1'b1;
      2'd2:    dec[1].last_of_run = 1'b1;
      2'd3:    dec[2].last_of_run = 1'b1;
      default: dec[0].last_of_run = 1'b0;
    endcase
  end

  // advance the result register: drain one record, load a decoded byte
  always_comb begin
    fill_nxt   = fill_r;
    res_nxt[0] = res_r[0];
    res_nxt[1] = res_r[1];
    res_nxt[2] = res_r[2];
    if (out_xfer) begin
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
      fill_nxt   = fill_r - 2'd1;
    end
    if (in_xfer) begin
      res_nxt[0] = dec[0];
      res_nxt[1] = dec[1];
      res_nxt[2] = dec[2];
      fill_nxt   = dec_n;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= sts_pkg::MODE_IDLE;
      count_r <= '0;
      fill_r  <= 2'd0;
    end else begin
      fill_r <= fill_nxt;
      if (in_xfer) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // hold result payload
  always_ff @(posedge clk) begin
    res_r[0] <= res_nxt[0];
    res_r[1] <= res_nxt[1];
    res_r[2] <= res_nxt[2];
  end

  // a zero byte always returns the scanner to between tokens
  a_nul_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_char_code == sts_pkg::CH_NUL) |=> (mode_r == sts_pkg::MODE_IDLE))
    else $error("scanner not idle after end of string");

  // no stored length outside a token
  a_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == sts_pkg::MODE_IDLE || mode_r == sts_pkg::MODE_SLASH ||
     mode_r == sts_pkg::MODE_COMMENT) |-> (count_r == '0))
    else $error("token count left set outside a token");

  // stored length saturates at the limit
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("token count beyond limit");

  // end of data is always the final record of its byte
  a_eod_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == sts_pkg::KIND_EOD) |-> out_last_of_run)
    else $error("end of data not marked last");

endmodule
`default_nettype wire

@@ tb/script_token_scanner_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// script_token_scanner_test: self-checking bench for the script token scanner
// Feeds text bytes through the valid/stall input, predicts the token records
// of every accepted byte and compares each record leaving the block, field by
// field, with the oldest prediction. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module script_token_scanner_test;

  localparam int TOKEN_MAX    = 128;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 40;
  localparam int BURST_ITEMS  = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] out_kind;
  logic [7:0] out_token_char;
  logic [7:0] out_token_length;
  logic       out_was_quoted;
  logic       out_discarded;
  logic       out_last_of_run;

  // tokeniser model state
  logic [2:0]       scan_state = sts_pkg::MODE_IDLE;
  int               token_bytes = 0;
  sts_pkg::result_t step_records[$];
  sts_pkg::result_t expected_records[$];

  int errors = 0;
  int counted_items = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 13;
  int hold_request = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  script_token_scanner #(
    .TOKEN_MAX(TOKEN_MAX)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_char_code(in_char_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_token_char(out_token_char),
    .out_token_length(out_token_length),
    .out_was_quoted(out_was_quoted),
    .out_discarded(out_discarded),
    .out_last_of_run(out_last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void push_record(input logic [1:0] kind, input logic [7:0] ch,
                                      input logic [7:0] len, input logic quoted,
                                      input logic drop);
    sts_pkg::result_t r;
    r.kind = kind;
    r.token_char = ch;
    r.token_length = len;
    r.was_quoted = quoted;
    r.discarded = drop;
    r.last_of_run = 1'b0;
    step_records.push_back(r);
  endfunction

  // store a word byte; bytes past the limit vanish silently
  function automatic void add_word_byte(input logic [7:0] c);
    if (token_bytes < TOKEN_MAX) begin
      token_bytes++;
      push_record(sts_pkg::KIND_BYTE, c, 8'h00, 1'b0, 1'b0);
    end
  endfunction

  // a word that filled the limit ends discarded with length zero
  function automatic void extend_word(input logic [7:0] c);
    if (c > sts_pkg::CH_SPACE) begin
      add_word_byte(c);
    end else begin
      if (token_bytes == TOKEN_MAX)
        push_record(sts_pkg::KIND_END, 8'h00, 8'h00, 1'b0, 1'b1);
      else
        push_record(sts_pkg::KIND_END, 8'h00, 8'(token_bytes), 1'b0, 1'b0);
      token_bytes = 0;
      scan_state = sts_pkg::MODE_IDLE;
      if (c == sts_pkg::CH_NUL)
        push_record(sts_pkg::KIND_EOD, 8'h00, 8'h00, 1'b0, 1'b0);
    end
  endfunction

  // advance the tokeniser by one byte and queue the records it produces
  function automatic int scan_char(input logic [7:0] c);
    int               n;
    sts_pkg::result_t r;
    step_records.delete();
    case (scan_state)
      sts_pkg::MODE_SLASH: begin
        if (c == sts_pkg::CH_SLASH) begin
          scan_state = sts_pkg::MODE_COMMENT;
        end else begin
          // a lone slash opens a word and the byte continues or ends it
          scan_state = sts_pkg::MODE_WORD;
          token_bytes = 0;
          add_word_byte(sts_pkg::CH_SLASH);
          extend_word(c);
        end
      end
      sts_pkg::MODE_COMMENT: begin
        if (c == sts_pkg::CH_NUL) begin
          push_record(sts_pkg::KIND_EOD, 8'h00, 8'h00, 1'b0, 1'b0);
          scan_state = sts_pkg::MODE_IDLE;
        end else if (c == sts_pkg::CH_NL) begin
          scan_state = sts_pkg::MODE_IDLE;
        end
      end
      sts_pkg::MODE_QUOTE: begin
        if (c == sts_pkg::CH_QUOTE || c == sts_pkg::CH_NUL) begin
          push_record(sts_pkg::KIND_END, 8'h00, 8'(token_bytes), 1'b1, 1'b0);
          if (c == sts_pkg::CH_NUL)
            push_record(sts_pkg::KIND_EOD, 8'h00, 8'h00, 1'b0, 1'b0);
          token_bytes = 0;
          scan_state = sts_pkg::MODE_IDLE;
        end else if (token_bytes < TOKEN_MAX) begin
          token_bytes++;
          push_record(sts_pkg::KIND_BYTE, c, 8'h00, 1'b0, 1'b0);
        end
      end
      sts_pkg::MODE_WORD: extend_word(c);
      default: begin
        scan_state = sts_pkg::MODE_IDLE;
        token_bytes = 0;
        if (c == sts_pkg::CH_NUL) begin
          push_record(sts_pkg::KIND_EOD, 8'h00, 8'h00, 1'b0, 1'b0);
        end else if (c > sts_pkg::CH_SPACE) begin
          if (c == sts_pkg::CH_SLASH) begin
            scan_state = sts_pkg::MODE_SLASH;
          end else if (c == sts_pkg::CH_QUOTE) begin
            scan_state = sts_pkg::MODE_QUOTE;
          end else begin
            scan_state = sts_pkg::MODE_WORD;
            add_word_byte(c);
          end
        end
      end
    endcase
    n = step_records.size();
    foreach (step_records[i]) begin
      r = step_records[i];
      r.last_of_run = (i == n - 1);
      expected_records.push_back(r);
    end
    return n;
  endfunction

  // ------------------------------------------------------------- checking

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  // check each result transfer and drive the output stall
  always @(posedge clk) begin : result_checker
    sts_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_records.size() == 0) begin
        $error("unexpected result: kind %0d, token_char %0d", out_kind, out_token_char);
        errors++;
      end else begin
        want = expected_records.pop_front();
        check_field("kind", want.kind, out_kind);
        check_field("token_char", want.token_char, out_token_char);
        check_field("token_length", want.token_length, out_token_length);
        check_field("was_quoted", want.was_quoted, out_was_quoted);
        check_field("discarded", want.discarded, out_discarded);
        check_field("last_of_run", want.last_of_run, out_last_of_run);
      end
    end
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct);
    if (hold_left > 0)
      hold_left--;
  end

  // end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------- stimulus

  // offer one byte, hold it until the transfer, then predict its records
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (in_stall);
    void'(scan_char(c));
    counted_items++;
  endtask

  // hold the input until every predicted record has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_records.size() != 0);
  endtask

  function automatic logic [7:0] word_char(input bit leading);
    logic [7:0] c;
    do c = 8'($urandom_range(255, 33));
    while (leading && (c == sts_pkg::CH_SLASH || c == sts_pkg::CH_QUOTE));
    return c;
  endfunction

  function automatic logic [7:0] quote_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == sts_pkg::CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 1)); while (c == sts_pkg::CH_NL);
    return c;
  endfunction

  task automatic send_word(input int len, input logic [7:0] tail);
    send_char(word_char(1'b1));
    for (int i = 1; i < len; i++)
      send_char(word_char(1'b0));
    send_char(tail);
  endtask

  task automatic send_quote(input int len, input logic [7:0] tail);
    send_char(sts_pkg::CH_QUOTE);
    for (int i = 0; i < len; i++)
      send_char(quote_char());
    send_char(tail);
  endtask

  // one random piece of text: mostly well-formed, some noise
  task automatic send_random_segment();
    int pick;
    pick = $urandom_range(99);
    if (pick < 35) begin
      send_word($urandom_range(12, 1), 8'($urandom_range(32, 0)));
    end else if (pick < 55) begin
      send_quote($urandom_range(10, 0),
                 ($urandom_range(9) == 0) ? sts_pkg::CH_NUL : sts_pkg::CH_QUOTE);
    end else if (pick < 67) begin
      send_char(sts_pkg::CH_SLASH);
      send_char(sts_pkg::CH_SLASH);
      repeat ($urandom_range(8, 0))
        send_char(comment_char());
      send_char(($urandom_range(7) == 0) ? sts_pkg::CH_NUL : sts_pkg::CH_NL);
    end else if (pick < 75) begin
      send_char(sts_pkg::CH_SLASH);
      send_char(8'($urandom_range(255)));
    end else if (pick < 85) begin
      repeat ($urandom_range(3, 1))
        send_char(8'($urandom_range(32, 1)));
    end else if (pick < 90) begin
      send_char(sts_pkg::CH_NUL);
    end else begin
      repeat ($urandom_range(4, 1))
        send_char(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------- tests

  // field extremes, quotes, comments, lone slashes and every way to end
  task automatic test_directed();
    logic [7:0] text[$] = '{
      8'h01, 8'hff, 8'h80, sts_pkg::CH_SPACE,
      sts_pkg::CH_QUOTE, 8'h01, sts_pkg::CH_SLASH, sts_pkg::CH_QUOTE,
      sts_pkg::CH_SLASH, sts_pkg::CH_SLASH, sts_pkg::CH_QUOTE, sts_pkg::CH_NL,
      sts_pkg::CH_SLASH, 8'h21, sts_pkg::CH_NUL,
      sts_pkg::CH_SLASH, sts_pkg::CH_SPACE,
      sts_pkg::CH_SLASH, sts_pkg::CH_NUL,
      sts_pkg::CH_QUOTE, sts_pkg::CH_QUOTE,
      sts_pkg::CH_QUOTE, 8'h6b, sts_pkg::CH_NUL,
      sts_pkg::CH_SLASH, sts_pkg::CH_SLASH, sts_pkg::CH_NUL,
      sts_pkg::CH_NUL
    };
    foreach (text[i])
      send_char(text[i]);
  endtask

  // a word past the length limit, with no idling on either side
  task automatic test_overlong_tokens();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(TOKEN_MAX + 1, sts_pkg::CH_SPACE);
    send_idle_pct = 13;
    recv_idle_pct = 13;
  endtask

  // stall the output for a long stretch while bytes keep coming
  task automatic test_output_hold_off();
    wait_drained();
    send_idle_pct = 0;
    hold_request = 150;
    repeat (3)
      send_random_segment();
    wait_drained();
    send_idle_pct = 13;
  endtask

  // random text, the first part with no idling on either side
  task automatic test_random_text();
    int start;
    start = counted_items;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (counted_items - start < BURST_ITEMS)
      send_random_segment();
    send_idle_pct = 13;
    recv_idle_pct = 13;
    while (counted_items - start < RANDOM_ITEMS)
      send_random_segment();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overlong_tokens();
    test_output_hold_off();
    test_random_text();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/sts_pkg.sv
rtl/core/script_token_scanner.sv
tb/script_token_scanner_test.sv
